@@ rtl/core/wwmf_pkg.sv @@
// ----------------------------------------------------------------------------
// wwmf_pkg
// shared types, sizes, register codes and window geometry of the weighted
// window mode filter
// ----------------------------------------------------------------------------
`default_nettype none

package wwmf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int ROW_W     = FH_W + 1;
  localparam int LBL_W     = 8;
  localparam int THR_W     = 8;
  localparam int WT_W      = 4;
  localparam int SPAN      = 3;
  localparam int CELLS     = SPAN * SPAN;
  localparam int CENTRE    = CELLS / 2;
  localparam int SUM_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WT0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WT1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WT2    = 3'd5;

  typedef logic [LBL_W-1:0] lbl_t;
  typedef logic [WT_W-1:0]  wt_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [COL_W-1:0] col_t;

  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } edge_ok_t;

  // manhattan distance of a window cell from the centre, row-major order
  function automatic logic [1:0] cell_dist(input int k);
    int dy;
    int dx;
    dy = k / SPAN - 1;
    dx = k % SPAN - 1;
    if (dy < 0) dy = -dy;
    if (dx < 0) dx = -dx;
    return 2'(dy + dx);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/weighted_window_mode_filter_unit.sv @@
// ----------------------------------------------------------------------------
// weighted_window_mode_filter_unit
// one pass of a 3x3 distance-weighted majority filter over a label map
// ----------------------------------------------------------------------------
// Takes one label per clock in raster order and returns one filtered label per
// clock; a pixel leaves frame_width + 1 transfers after it enters, so after the
// frame the host sends that many padding transfers to flush the last rows.
// Two line memories hold the previous rows, a five-stage pipeline (line read,
// window, compare, weighted sum, vote) sustains one transfer per cycle and
// stalls without loss under output backpressure.
`default_nettype none

module weighted_window_mode_filter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // label_in
  input  wire logic                          in_tuser,   // padding
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [7:0]                    out_tdata,  // label_out
  output logic                               out_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [wwmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wwmf_pkg::CFG_DAT_W-1:0] cfg_data
);

  import wwmf_pkg::*;

  // configuration
  logic [FW_W-1:0]  width_r;
  logic [FH_W-1:0]  height_r;
  logic [THR_W-1:0] thresh_r;
  wt_t              wt_r [3];

  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FW_W'(640);
      height_r <= FH_W'(480);
      thresh_r <= THR_W'(6);
      wt_r[0]  <= WT_W'(1);
      wt_r[1]  <= WT_W'(1);
      wt_r[2]  <= WT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[FW_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[FH_W-1:0];
        REG_THRESH: thresh_r <= cfg_data[THR_W-1:0];
        REG_WT0:    wt_r[0]  <= cfg_data[WT_W-1:0];
        REG_WT1:    wt_r[1]  <= cfg_data[WT_W-1:0];
        REG_WT2:    wt_r[2]  <= cfg_data[WT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) w_eff = FW_W'(1);
    else if (width_r > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
    else w_eff = width_r;
    h_eff = (height_r == '0) ? FH_W'(1) : height_r;
  end

  // handshake chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic adv1, adv2, adv3, adv4, adv_o, accept;

  assign adv_o     = !out_v_r | out_tready;
  assign adv4      = !s4_v_r | adv_o;
  assign adv3      = !s3_v_r | adv4;
  assign adv2      = !s2_v_r | adv3;
  assign adv1      = !s1_v_r | adv2;
  assign in_tready = adv1;
  assign accept    = in_tvalid & adv1;

  // raster position
  col_t             col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             c0, has, past, fe, res, clr;
  logic [ROW_W-1:0] oy;
  logic [FW_W-1:0]  ox;
  edge_ok_t         ok;

  always_comb begin
    c0   = (col_r == '0);
    has  = c0 ? (row_r >= ROW_W'(2)) : (row_r >= ROW_W'(1));
    oy   = c0 ? row_r - ROW_W'(2) : row_r - ROW_W'(1);
    ox   = c0 ? w_eff - FW_W'(1) : FW_W'(col_r) - FW_W'(1);
    past = (oy >= ROW_W'(h_eff));
    fe   = (oy == ROW_W'(h_eff) - ROW_W'(1)) && (ox == w_eff - FW_W'(1));
    res  = has & !past;
    clr  = has & (past | fe);
    ok.top   = (oy != '0);
    ok.bot   = (oy + ROW_W'(1) < ROW_W'(h_eff));
    ok.left  = (ox != '0);
    ok.right = (ox + FW_W'(1) < w_eff);
    if (clr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (FW_W'(col_r) + FW_W'(1) >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line memory read
  logic     s1_res_r, s1_fe_r, byp_r;
  edge_ok_t s1_ok_r;
  col_t     s1_col_r;
  lbl_t     s1_lbl_r, byp_lbl_r;
  lbl_t     rd1, rd2;
  logic     lb2_we;

  assign lb2_we = s1_v_r & adv2;

  wwmf_ram #(.WIDTH(LBL_W), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk  (clk),
    .we   (accept),
    .waddr(col_r),
    .wdata(in_tdata),
    .re   (accept),
    .raddr(col_r),
    .rdata(rd1)
  );

  wwmf_ram #(.WIDTH(LBL_W), .DEPTH(MAX_WIDTH)) u_line2 (
    .clk  (clk),
    .we   (lb2_we),
    .waddr(s1_col_r),
    .wdata(rd1),
    .re   (accept),
    .raddr(col_r),
    .rdata(rd2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r  <= res;
      s1_fe_r   <= fe;
      s1_ok_r   <= ok;
      s1_col_r  <= col_r;
      s1_lbl_r  <= in_tdata;
      byp_r     <= lb2_we && (s1_col_r == col_r);
      byp_lbl_r <= rd1;
    end
  end

  // stage 2: window
  lbl_t             col_a_r [SPAN];
  lbl_t             col_b_r [SPAN];
  lbl_t             trip [SPAN];
  logic             s2_res_r, s2_fe_r;
  lbl_t             s2_win_r [CELLS];
  logic [CELLS-1:0] s2_val_r;
  lbl_t             win_nxt [CELLS];
  logic [CELLS-1:0] val_nxt;
  logic [SPAN-1:0]  row_ok, col_ok;

  always_comb begin
    trip[0] = byp_r ? byp_lbl_r : rd2;
    trip[1] = rd1;
    trip[2] = s1_lbl_r;
    row_ok  = {s1_ok_r.bot, 1'b1, s1_ok_r.top};
    col_ok  = {s1_ok_r.right, 1'b1, s1_ok_r.left};
    for (int t = 0; t < SPAN; t++) begin
      win_nxt[t*SPAN]     = col_a_r[t];
      win_nxt[t*SPAN + 1] = col_b_r[t];
      win_nxt[t*SPAN + 2] = trip[t];
      for (int d = 0; d < SPAN; d++) begin
        val_nxt[t*SPAN + d] = row_ok[t] & col_ok[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_res_r <= s1_res_r;
      s2_fe_r  <= s1_fe_r;
      s2_win_r <= win_nxt;
      s2_val_r <= val_nxt;
      col_a_r  <= col_b_r;
      col_b_r  <= trip;
    end
  end

  // stage 3: label compares and cell weights
  logic             s3_res_r, s3_fe_r;
  lbl_t             s3_win_r [CELLS];
  logic [CELLS-1:0] s3_val_r;
  logic [CELLS-1:0] s3_eq_r [CELLS];
  wt_t              s3_wt_r [CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_v_r) begin
      s3_res_r <= s2_res_r;
      s3_fe_r  <= s2_fe_r;
      s3_win_r <= s2_win_r;
      s3_val_r <= s2_val_r;
      for (int i = 0; i < CELLS; i++) begin
        for (int j = 0; j < CELLS; j++) begin
          s3_eq_r[i][j] <= (s2_win_r[i] == s2_win_r[j]);
        end
        s3_wt_r[i] <= s2_val_r[i] ? wt_r[cell_dist(i)] : '0;
      end
    end
  end

  // stage 4: per-label weighted sums
  logic             s4_res_r, s4_fe_r;
  lbl_t             s4_win_r [CELLS];
  logic [CELLS-1:0] s4_first_r;
  sum_t             s4_sum_r [CELLS];
  sum_t             sum_nxt [CELLS];
  logic [CELLS-1:0] first_nxt;

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      sum_nxt[i]   = '0;
      first_nxt[i] = s3_val_r[i];
      for (int j = 0; j < CELLS; j++) begin
        if (s3_eq_r[i][j]) sum_nxt[i] = sum_nxt[i] + SUM_W'(s3_wt_r[j]);
        if (j < i && s3_val_r[j] && s3_eq_r[i][j]) first_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && s3_v_r) begin
      s4_res_r   <= s3_res_r;
      s4_fe_r    <= s3_fe_r;
      s4_win_r   <= s3_win_r;
      s4_first_r <= first_nxt;
      s4_sum_r   <= sum_nxt;
    end
  end

  // stage 5: vote and output register
  logic [CELLS-1:0] hit;
  logic             single;
  lbl_t             pick, vote;
  lbl_t             out_lbl_r;
  logic             out_fe_r;

  always_comb begin
    pick = '0;
    for (int i = 0; i < CELLS; i++) begin
      hit[i] = s4_first_r[i] && (THR_W'(s4_sum_r[i]) >= thresh_r);
      if (hit[i]) pick = pick | s4_win_r[i];
    end
    single = (hit != '0) && ((hit & (hit - CELLS'(1))) == '0);
    vote   = single ? pick : s4_win_r[CENTRE];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv_o) begin
      out_v_r <= s4_v_r & s4_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && s4_v_r) begin
      out_lbl_r <= vote;
      out_fe_r  <= s4_fe_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_lbl_r;
  assign out_tlast  = out_fe_r;

endmodule

`default_nettype wire

@@ rtl/core/wwmf_ram.sv @@
// ----------------------------------------------------------------------------
// wwmf_ram
// simple dual-port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module wwmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ tb/weighted_window_mode_filter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// weighted_window_mode_filter_unit_tb
// self-checking bench for the weighted window mode filter
// ----------------------------------------------------------------------------
// Streams whole label frames, each followed by its flush transfers, under many
// geometries, thresholds and weight sets. A directed table comes first, then
// random frames. Each result transfer is checked against a predicted label
// and frame-end flag. Random idles are applied on both sides. One long output
// hold-off fills the pipeline.
`default_nettype none

module weighted_window_mode_filter_unit_tb;
  import wwmf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_WT3 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WT4 = 3'd7;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int ITEM_TARGET = 1450;

  typedef struct packed {
    logic [7:0] lbl;
    logic       last;
  } filt_px_t;

  typedef struct {
    logic [7:0] lbl;
    logic       pad;
    bit         typed;
    logic [7:0] exp_lbl;
    logic       exp_last;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  filt_px_t pending_px[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned frames_done;
  int unsigned cfg_writes;
  bit hold_req;
  bit hold_done;

  // filter state mirror
  int unsigned geo_w;
  int unsigned geo_h;
  int unsigned vote_thr;
  int unsigned dist_wt[5];
  logic [7:0] line_mem[STORE_DEPTH];
  int unsigned col_pos;
  int unsigned row_pos;

  weighted_window_mode_filter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout after %0d results", results_seen);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic vote_pixel(input logic [7:0] lbl, output bit has, output filt_px_t px);
    longint w;
    longint h;
    longint total;
    longint n;
    longint q;
    longint oy;
    longint ox;
    longint y;
    longint x;
    bit ok[CELLS];
    int unsigned wt[CELLS];
    logic [7:0] lab[CELLS];
    int unsigned hits;
    int unsigned sum;
    logic [7:0] pick;
    bit seen;
    int k;
    int ady;
    int adx;
    w = (geo_w == 0) ? 1 : (geo_w > MAX_WIDTH) ? MAX_WIDTH : geo_w;
    h = (geo_h == 0) ? 1 : geo_h;
    total = w * h;
    n = longint'(row_pos) * w + col_pos;
    has = 1'b0;
    px = '0;
    hits = 0;
    pick = '0;
    if (n < total) line_mem[n % STORE_DEPTH] = lbl;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    q = n - (w + 1);
    if (q < 0) return;
    if (q >= total) begin
      col_pos = 0;
      row_pos = 0;
      return;
    end
    oy = q / w;
    ox = q % w;
    for (k = 0; k < CELLS; k++) begin
      y = oy + k / SPAN - 1;
      x = ox + k % SPAN - 1;
      ady = (k / SPAN == 1) ? 0 : 1;
      adx = (k % SPAN == 1) ? 0 : 1;
      ok[k] = (x >= 0 && x < w && y >= 0 && y < h);
      wt[k] = dist_wt[ady + adx];
      lab[k] = ok[k] ? line_mem[(y * w + x) % STORE_DEPTH] : 8'd0;
    end
    for (int i = 0; i < CELLS; i++) begin
      if (ok[i]) begin
        seen = 1'b0;
        sum = 0;
        for (int j = 0; j < i; j++)
          if (ok[j] && lab[j] == lab[i]) seen = 1'b1;
        if (!seen) begin
          for (int j = 0; j < CELLS; j++)
            if (ok[j] && lab[j] == lab[i]) sum += wt[j];
          if (sum >= vote_thr) begin
            hits++;
            pick = lab[i];
          end
        end
      end
    end
    has = 1'b1;
    px.lbl = (hits == 1) ? pick : lab[CENTRE];
    px.last = (q == total - 1);
    if (px.last) begin
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      REG_WIDTH:  geo_w = val[10:0];
      REG_HEIGHT: geo_h = val[12:0];
      REG_THRESH: vote_thr = val[7:0];
      REG_WT0:    dist_wt[0] = val[3:0];
      REG_WT1:    dist_wt[1] = val[3:0];
      REG_WT2:    dist_wt[2] = val[3:0];
      REG_WT3:    dist_wt[3] = val[3:0];
      REG_WT4:    dist_wt[4] = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper bits beyond each field are random and must be dropped by the block
  task automatic setup_filter(input int unsigned w, input int unsigned h, input int unsigned thr,
                              input int unsigned w0, input int unsigned w1,
                              input int unsigned w2);
    write_reg(REG_WIDTH, {2'($urandom), 11'(w)});
    write_reg(REG_HEIGHT, 13'(h));
    write_reg(REG_THRESH, {5'($urandom), 8'(thr)});
    write_reg(REG_WT0, {9'($urandom), 4'(w0)});
    write_reg(REG_WT1, {9'($urandom), 4'(w1)});
    write_reg(REG_WT2, {9'($urandom), 4'(w2)});
    write_reg(REG_WT3, {9'($urandom), 4'($urandom)});
    write_reg(REG_WT4, {9'($urandom), 4'($urandom)});
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_px.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_px(input logic [7:0] lbl, input logic pad, input bit typed,
                         input filt_px_t typed_px);
    bit has;
    filt_px_t px;
    bool_idle: while (!(items_sent >= 600 && items_sent < 900) &&
                      $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= lbl;
    in_tuser  <= pad;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    vote_pixel(lbl, has, px);
    if (has) pending_px.push_back(typed ? typed_px : px);
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h, input bit hold_here);
    int unsigned ew;
    int unsigned eh;
    logic [7:0] pal[3];
    logic [7:0] lbl;
    ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    eh = (h == 0) ? 1 : h;
    foreach (pal[i]) pal[i] = 8'($urandom);
    for (int unsigned i = 0; i < ew * eh; i++) begin
      lbl = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pal[$urandom_range(0, 2)];
      if (hold_here && i == 2) hold_req = 1'b1;
      send_px(lbl, ($urandom_range(0, 9) == 0), 1'b0, '0);
    end
    for (int unsigned i = 0; i < ew + 1; i++)
      send_px(8'($urandom), ($urandom_range(0, 9) != 0), 1'b0, '0);
    frames_done++;
  endtask

  // output side: random stalls, one long hold-off, one quiet stretch
  initial begin
    int unsigned cyc;
    int unsigned held;
    cyc = 0;
    held = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        held++;
        if (held >= 400) hold_done = 1'b1;
      end else if (cyc >= 2000 && cyc < 3500) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    filt_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_px.size() == 0) begin
        report($sformatf("unexpected result label %0d", out_tdata));
      end else begin
        want = pending_px.pop_front();
        if (out_tdata !== want.lbl)
          report($sformatf("label_out %0d, want %0d", out_tdata, want.lbl));
        if (out_tlast !== want.last)
          report($sformatf("frame_end %0b, want %0b", out_tlast, want.last));
      end
    end
  end

  initial begin
    dir_row_t dir_tab[16];
    int unsigned fw;
    int unsigned fh;
    int unsigned thr;
    filt_px_t tp;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    frames_done = 0;
    cfg_writes = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    geo_w = 640;
    geo_h = 480;
    vote_thr = 6;
    dist_wt = '{1, 1, 1, 0, 0};
    col_pos = 0;
    row_pos = 0;
    foreach (line_mem[i]) line_mem[i] = '0;

    // single-pixel frames keep their own label, then a 3x2 frame with a
    // padding flag inside the frame
    dir_tab = '{
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'hAA,  1'b1, 1'b0, 8'd0,   1'b0},
      '{8'h55,  1'b1, 1'b1, 8'd0,   1'b1},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd0,   1'b1, 1'b1, 8'd255, 1'b1},
      '{8'd7,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd7,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd9,   1'b1, 1'b0, 8'd0,   1'b0},
      '{8'd7,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd9,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd9,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd1,   1'b1, 1'b0, 8'd0,   1'b0},
      '{8'd2,   1'b1, 1'b0, 8'd0,   1'b0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    setup_filter(1, 1, 0, 9, 9, 9);
    foreach (dir_tab[i]) begin
      if (i == 6) begin
        drain_results();
        setup_filter(3, 2, 3, 1, 2, 1);
      end
      tp.lbl = dir_tab[i].exp_lbl;
      tp.last = dir_tab[i].exp_last;
      send_px(dir_tab[i].lbl, dir_tab[i].pad, dir_tab[i].typed, tp);
    end
    frames_done += 3;

    for (int f = 0; items_sent < ITEM_TARGET; f++) begin
      drain_results();
      case (f)
        3: begin fw = 0; fh = 0; end
        5: begin fw = 10; fh = 6; end
        8: begin fw = 1; fh = 0; end
        12: begin fw = 1; fh = 120; end
        20: begin fw = 128; fh = 2; end
        28: begin fw = 40; fh = 3; end
        default: begin fw = $urandom_range(1, 10); fh = $urandom_range(1, 6); end
      endcase
      case ($urandom_range(0, 9))
        0: thr = 0;
        1: thr = 255;
        2: thr = $urandom_range(0, 255);
        default: thr = $urandom_range(1, 20);
      endcase
      setup_filter(fw, fh, thr, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15));
      send_frame(fw, fh, (f == 5));
    end

    drain_results();
    $display("covered %0d frames, %0d input transfers, %0d result transfers, %0d register writes",
             frames_done, items_sent, results_seen, cfg_writes);
    $display("geometries from 1x1 up to 128 wide and 120 rows, thresholds 0 to 255");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/wwmf_pkg.sv
rtl/core/wwmf_ram.sv
rtl/core/weighted_window_mode_filter_unit.sv
tb/weighted_window_mode_filter_unit_tb.sv
